>>> src/rspf_pkg.sv
// ----------------------------------------------------------------------------
// rspf_pkg: shared types and constants of the radar sentence presence filter
// Holds the item kinds, number scanner phases, tag strings and the struct
// that carries a classified item from the front end to the back end.
// ----------------------------------------------------------------------------
package rspf_pkg;

   localparam int LINE_MAX_CHARS_DEF = 127;
   localparam int MAX_FIELDS_DEF     = 8;
   localparam int TIME_WIDTH_DEF     = 32;

   localparam logic [31:0] ABSENT_TIMEOUT_RESET = 32'd5000;
   localparam logic [31:0] HEARTBEAT_RESET      = 32'd3000;

   localparam logic CSR_ABSENT_TIMEOUT = 1'b0;
   localparam logic CSR_HEARTBEAT      = 1'b1;

   localparam logic CMD_BYTE = 1'b0;
   localparam logic CMD_TICK = 1'b1;

   localparam logic [23:0] C24_MAX = 24'h7FFFFF;
   localparam logic [23:0] C24_MIN = 24'h800000;
   localparam logic [31:0] C32_MAX = 32'h7FFFFFFF;
   localparam logic [31:0] C32_MIN = 32'h80000000;

   typedef enum logic [1:0] {
      PH_LEAD = 2'd0,
      PH_INT  = 2'd1,
      PH_FRAC = 2'd2,
      PH_STOP = 2'd3
   } phase_type;

   typedef struct packed {
      phase_type  phase;
      logic       neg;
      logic [1:0] fcnt;
   } scan_type;

   localparam logic [47:0] TAG_DMD = {8'h24, 8'h44, 8'h46, 8'h44, 8'h4D, 8'h44};
   localparam logic [47:0] TAG_HPD = {8'h24, 8'h44, 8'h46, 8'h48, 8'h50, 8'h44};

   // A finished line, or a tick, handed to the back end.
   typedef struct packed {
      logic        tick;
      logic        is_dmd;
      logic        is_hpd;
      logic        targets_pos;
      logic        targets_nz;
      logic [23:0] range;
      logic [23:0] speed;
      logic        sink_ready;
   } line_type;

   function automatic logic [7:0] tag_char(input logic [47:0] tag, input logic [2:0] pos);
      logic [7:0] c;
      c = 8'h00;
      for (int i = 0; i < 6; i++) begin
         if (pos == 3'(i)) c = tag[8*(5-i) +: 8];
      end
      return c;
   endfunction

endpackage

>>> src/rspf_scan.sv
// ----------------------------------------------------------------------------
// rspf_scan: one step of the decimal number scanner
// Updates a scanner state and an accumulator for one character, saturating
// to 32 bits for integers or to 24 bits for hundredths.
// ----------------------------------------------------------------------------
module rspf_scan
   import rspf_pkg::*;
(
   input  logic [7:0]  ch,
   input  logic        is_float,
   input  scan_type    st_in,
   input  logic [31:0] acc_in,
   output scan_type    st_out,
   output logic [31:0] acc_out
);
   logic        digit;
   logic [3:0]  d;
   logic signed [39:0] v10, dd, sum, lo, hi;
   logic        ws;

   always_comb begin
      digit = (ch >= 8'h30) && (ch <= 8'h39);
      d = digit ? 4'(ch - 8'h30) : 4'd0;
      ws = (ch == 8'h20) || (ch == 8'h09) || (ch == 8'h0B) || (ch == 8'h0C);
      lo = is_float ? 40'(signed'(C24_MIN)) : 40'(signed'(C32_MIN));
      hi = is_float ? 40'(signed'(C24_MAX)) : 40'(signed'(C32_MAX));
      v10 = 40'(signed'(acc_in)) * 40'sd10;
      dd = 40'(d);
      st_out = st_in;
      acc_out = acc_in;
      sum = 40'sd0;
      if (st_in.phase == PH_STOP || (st_in.phase == PH_LEAD && ws)) begin
         st_out = st_in;
      end else if (st_in.phase == PH_LEAD && (ch == 8'h2B || ch == 8'h2D)) begin
         st_out.neg = (ch == 8'h2D);
         st_out.phase = PH_INT;
      end else if ((st_in.phase == PH_LEAD || st_in.phase == PH_INT) && digit) begin
         st_out.phase = PH_INT;
         if (is_float) dd = dd * 40'sd100;
         sum = st_in.neg ? v10 - dd : v10 + dd;
         acc_out = (sum < lo) ? 32'(lo) : ((sum > hi) ? 32'(hi) : 32'(sum));
      end else if ((st_in.phase == PH_LEAD || st_in.phase == PH_INT) && is_float
                   && ch == 8'h2E) begin
         st_out.phase = PH_FRAC;
      end else if (st_in.phase == PH_FRAC && digit) begin
         if (st_in.fcnt != 2'd2) begin
            if (st_in.fcnt == 2'd0) dd = dd * 40'sd10;
            sum = 40'(signed'(acc_in));
            sum = st_in.neg ? sum - dd : sum + dd;
            acc_out = (sum < lo) ? 32'(lo) : ((sum > hi) ? 32'(hi) : 32'(sum));
            st_out.fcnt = st_in.fcnt + 2'd1;
         end
      end else begin
         st_out.phase = PH_STOP;
      end
   end
endmodule

>>> src/rspf_front.sv
// ----------------------------------------------------------------------------
// rspf_front: line assembler and field decoder
// Takes bytes and ticks, decodes fields as they stream in and passes a
// classified line or a tick to the back end through its queue.
// ----------------------------------------------------------------------------
module rspf_front
   import rspf_pkg::*;
#(
   parameter int LINE_MAX_CHARS = LINE_MAX_CHARS_DEF,
   parameter int MAX_FIELDS     = MAX_FIELDS_DEF
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_stall,
   input  logic     req_command,
   input  logic [7:0] req_byte_value,
   input  logic     req_sink_ready,
   output logic     q_push,
   output line_type q_data,
   input  logic     q_full
);
   localparam int CW = $clog2(LINE_MAX_CHARS + 1);
   localparam int FW = $clog2(MAX_FIELDS + 2);

   logic [CW-1:0] kept_ff, kept_in;
   logic [FW-1:0] fidx_ff, fidx_in;
   logic          inside_ff, inside_in, nul_ff, nul_in;
   logic [1:0]    tagm_ff, tagm_in;
   logic [2:0]    tpos_ff, tpos_in;
   logic [31:0]   tgt_ff, tgt_in, rng_ff, rng_in, spd_ff, spd_in;
   scan_type      scan_ff, scan_in;

   logic          take, term, keep, nf;
   logic [FW-1:0] f;
   logic [FW-1:0] cnt;
   scan_type      scan_start, sout;
   logic [31:0]   acc_sel, aout;
   logic          is_float;

   assign req_stall = q_full;
   assign take = req_valid && !q_full;
   assign term = (req_command == CMD_BYTE) &&
                 (req_byte_value == 8'h0A || req_byte_value == 8'h0D);

   always_comb begin
      nf = !inside_ff;
      f = (nf && fidx_ff <= FW'(MAX_FIELDS)) ? fidx_ff : fidx_ff - FW'(1);
      scan_start = nf ? scan_type'(5'd0) : scan_ff;
      is_float = (f != FW'(1));
      acc_sel = (f == FW'(1)) ? tgt_ff : ((f == FW'(3)) ? rng_ff : spd_ff);
   end

   rspf_scan u_scan (
      .ch(req_byte_value), .is_float(is_float), .st_in(scan_start),
      .acc_in(acc_sel), .st_out(sout), .acc_out(aout)
   );

   always_comb begin
      kept_in = kept_ff; fidx_in = fidx_ff; inside_in = inside_ff; nul_in = nul_ff;
      tagm_in = tagm_ff; tpos_in = tpos_ff; tgt_in = tgt_ff; rng_in = rng_ff;
      spd_in = spd_ff; scan_in = scan_ff;
      keep = take && req_command == CMD_BYTE && !term &&
             kept_ff < CW'(LINE_MAX_CHARS);
      cnt = (fidx_ff > FW'(MAX_FIELDS)) ? FW'(MAX_FIELDS) : fidx_ff;
      q_push = 1'b0;
      q_data = '0;
      q_data.sink_ready = req_sink_ready;
      q_data.range = rng_ff[23:0];
      q_data.speed = spd_ff[23:0];
      q_data.targets_pos = !tgt_ff[31] && (tgt_ff != 32'd0);
      q_data.targets_nz = (tgt_ff != 32'd0);
      q_data.is_dmd = tagm_ff[0] && cnt >= FW'(5);
      q_data.is_hpd = tagm_ff[1];
      if (take && req_command == CMD_TICK) begin
         q_data.tick = 1'b1;
         q_push = 1'b1;
      end else if (take && term) begin
         if (kept_ff != '0) begin
            q_push = (cnt >= FW'(2)) && (tpos_ff == 3'd6) &&
                     (q_data.is_dmd || q_data.is_hpd);
            kept_in = '0; fidx_in = '0; inside_in = 1'b0; nul_in = 1'b0;
            tagm_in = 2'b11; tpos_in = '0; tgt_in = '0; rng_in = '0; spd_in = '0;
            scan_in = scan_type'(5'd0);
         end
      end else if (keep) begin
         kept_in = kept_ff + CW'(1);
         if (nul_ff) begin
            kept_in = kept_ff + CW'(1);
         end else if (req_byte_value == 8'h00) begin
            nul_in = 1'b1; inside_in = 1'b0;
         end else if (req_byte_value == 8'h2C) begin
            inside_in = 1'b0;
         end else begin
            inside_in = 1'b1;
            if (nf) begin
               scan_in = scan_type'(5'd0);
               if (fidx_ff <= FW'(MAX_FIELDS)) fidx_in = fidx_ff + FW'(1);
            end
            if (f == FW'(0)) begin
               if (tpos_ff < 3'd6) begin
                  if (req_byte_value != tag_char(TAG_DMD, tpos_ff)) tagm_in[0] = 1'b0;
                  if (req_byte_value != tag_char(TAG_HPD, tpos_ff)) tagm_in[1] = 1'b0;
               end else begin
                  tagm_in = 2'b00;
               end
               if (tpos_ff < 3'd7) tpos_in = tpos_ff + 3'd1;
            end else if (f == FW'(1) || f == FW'(3) || f == FW'(4)) begin
               scan_in = sout;
               if (f == FW'(1)) tgt_in = aout;
               else if (f == FW'(3)) rng_in = aout;
               else spd_in = aout;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kept_ff <= '0; fidx_ff <= '0; inside_ff <= 1'b0; nul_ff <= 1'b0;
         tagm_ff <= 2'b11; tpos_ff <= '0; tgt_ff <= '0; rng_ff <= '0; spd_ff <= '0;
         scan_ff <= scan_type'(5'd0);
      end else begin
         kept_ff <= kept_in; fidx_ff <= fidx_in; inside_ff <= inside_in;
         nul_ff <= nul_in; tagm_ff <= tagm_in; tpos_ff <= tpos_in;
         tgt_ff <= tgt_in; rng_ff <= rng_in; spd_ff <= spd_in; scan_ff <= scan_in;
      end
   end
endmodule

>>> src/rspf_queue.sv
// ----------------------------------------------------------------------------
// rspf_queue: two-entry queue between the front and back ends
// ----------------------------------------------------------------------------
module rspf_queue
   import rspf_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  line_type push_data,
   output logic     full,
   output logic     pop_valid,
   output line_type pop_data,
   input  logic     pop
);
   line_type   mem_ff [2];
   logic       wp_ff, rp_ff;
   logic [1:0] cnt_ff;

   assign full = (cnt_ff == 2'd2);
   assign pop_valid = (cnt_ff != 2'd0);
   assign pop_data = mem_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (push) mem_ff[wp_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= 1'b0; rp_ff <= 1'b0; cnt_ff <= 2'd0;
      end else begin
         if (push) wp_ff <= !wp_ff;
         if (pop) rp_ff <= !rp_ff;
         cnt_ff <= cnt_ff + 2'(push) - 2'(pop);
      end
   end
endmodule

>>> src/rspf_back.sv
// ----------------------------------------------------------------------------
// rspf_back: tick counter, absence debounce and send policy
// Applies one queued entry a cycle unless stalled, into an output register.
// ----------------------------------------------------------------------------
module rspf_back
   import rspf_pkg::*;
#(
   parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write,
   input  logic [0:0]  csr_index,
   input  logic [31:0] csr_data,
   input  logic        q_valid,
   input  line_type    q_data,
   output logic        q_pop,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_present,
   output logic [23:0] rsp_range_centi,
   output logic [23:0] rsp_speed_centi
);
   localparam int XW = (TIME_WIDTH > 32) ? TIME_WIDTH : 32;

   logic [31:0] tmo_ff, hb_ff;
   logic [TIME_WIDTH-1:0] now_ff, now_in, abs_ff, abs_in, last_ff, last_in, da, dh;
   logic act_ff, act_in, lsp_ff, lsp_in;
   logic ov_ff, ov_in, op_ff, op_in;
   logic [23:0] or_ff, or_in, os_ff, os_in;
   logic p, send;

   assign q_pop = q_valid && !(rsp_valid && rsp_stall);

   always_comb begin
      now_in = now_ff; abs_in = abs_ff; last_in = last_ff; act_in = act_ff;
      lsp_in = lsp_ff; ov_in = rsp_valid && rsp_stall;
      op_in = op_ff; or_in = or_ff; os_in = os_ff;
      p = 1'b0; send = 1'b0; da = '0; dh = '0;
      if (q_pop) begin
         if (q_data.tick) begin
            now_in = now_ff + TIME_WIDTH'(1);
         end else begin
            p = q_data.is_dmd ? q_data.targets_pos : q_data.targets_nz;
            if (p) begin
               act_in = 1'b0;
            end else begin
               if (!act_ff) begin
                  act_in = 1'b1; abs_in = now_ff;
               end
               da = now_ff - (act_ff ? abs_ff : now_ff);
               if (XW'(da) < XW'(tmo_ff)) p = 1'b1;
            end
            dh = now_ff - last_ff;
            send = ((p != lsp_ff) || (p && XW'(dh) >= XW'(hb_ff))) && q_data.sink_ready;
            if (send) begin
               lsp_in = p; last_in = now_ff; ov_in = 1'b1; op_in = p;
               or_in = q_data.is_dmd ? q_data.range : 24'd0;
               os_in = q_data.is_dmd ? q_data.speed : 24'd0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tmo_ff <= ABSENT_TIMEOUT_RESET; hb_ff <= HEARTBEAT_RESET;
         now_ff <= '0; abs_ff <= '0; last_ff <= '0; act_ff <= 1'b0;
         lsp_ff <= 1'b0; ov_ff <= 1'b0;
      end else begin
         if (csr_write && csr_index == CSR_ABSENT_TIMEOUT) tmo_ff <= csr_data;
         if (csr_write && csr_index == CSR_HEARTBEAT) hb_ff <= csr_data;
         now_ff <= now_in; abs_ff <= abs_in; last_ff <= last_in; act_ff <= act_in;
         lsp_ff <= lsp_in; ov_ff <= ov_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff <= op_in; or_ff <= or_in; os_ff <= os_in;
   end

   assign rsp_valid = ov_ff;
   assign rsp_present = op_ff;
   assign rsp_range_centi = or_ff;
   assign rsp_speed_centi = os_ff;
endmodule

>>> src/radar_sentence_presence_filter.sv
// ----------------------------------------------------------------------------
// radar_sentence_presence_filter: presence reports from radar text lines
// Top level tying the line decoder, its queue and the debounce back end.
// ----------------------------------------------------------------------------
// The front end decodes a character a cycle and the back end applies one
// queued entry a cycle, so beats, bytes or ticks, may follow back to back;
// the two-entry queue and the result register stall the input only once the
// result side has stalled. A line yields at most one result beat, through the
// queue and then the result register, after its terminator is taken.
module radar_sentence_presence_filter
   import rspf_pkg::*;
#(
   parameter int LINE_MAX_CHARS = LINE_MAX_CHARS_DEF,
   parameter int MAX_FIELDS     = MAX_FIELDS_DEF,
   parameter int TIME_WIDTH     = TIME_WIDTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write,
   input  logic [0:0]  csr_index,
   input  logic [31:0] csr_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_command,
   input  logic [7:0]  req_byte_value,
   input  logic        req_sink_ready,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_present,
   output logic [23:0] rsp_range_centi,
   output logic [23:0] rsp_speed_centi
);
   logic     push, full, pop_valid, pop;
   line_type push_data, pop_data;

   rspf_front #(.LINE_MAX_CHARS(LINE_MAX_CHARS), .MAX_FIELDS(MAX_FIELDS)) u_front (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
      .req_command(req_command), .req_byte_value(req_byte_value),
      .req_sink_ready(req_sink_ready), .q_push(push), .q_data(push_data), .q_full(full)
   );

   rspf_queue u_queue (
      .clock(clock), .reset(reset), .push(push), .push_data(push_data), .full(full),
      .pop_valid(pop_valid), .pop_data(pop_data), .pop(pop)
   );

   rspf_back #(.TIME_WIDTH(TIME_WIDTH)) u_back (
      .clock(clock), .reset(reset), .csr_write(csr_write), .csr_index(csr_index),
      .csr_data(csr_data), .q_valid(pop_valid), .q_data(pop_data), .q_pop(pop),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_present(rsp_present),
      .rsp_range_centi(rsp_range_centi), .rsp_speed_centi(rsp_speed_centi)
   );
endmodule

>>> src/rspf_checker.sv
// ----------------------------------------------------------------------------
// rspf_checker: port-level checks of the presence filter
// ----------------------------------------------------------------------------
module rspf_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic        rsp_present,
   input logic [23:0] rsp_range_centi
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_present) &&
                                 $stable(rsp_range_centi))
      else $error("result beat changed while stalled");

   a_no_stall_idle: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |=> !req_stall)
      else $error("input stalled while result side idle");

   a_reset_clean: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result beat right after reset");

   // The sender keeps a stalled input beat on offer until it is taken.
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid)
      else $error("input beat withdrawn while stalled");
endmodule

bind radar_sentence_presence_filter rspf_checker u_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
   .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_present(rsp_present),
   .rsp_range_centi(rsp_range_centi)
);
